// ===== src/mtmr_pkg.sv =====
// shared constants, types and dimension clamping for the mirror tiled matrix reader
package mtmr_pkg;

  // source matrix capacity
  localparam int MAX_ROWS = 32;
  localparam int MAX_COLS = 32;

  // field widths
  localparam int IDX_W  = 7;
  localparam int DATA_W = 64;
  localparam int DIM_W  = 6;

  // wide enough for 3 * MAX and for the flattened address arithmetic
  localparam int EXT_W  = 10;
  localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int COL_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int DEPTH  = MAX_ROWS * MAX_COLS;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int AEXT_W = ADDR_W + 2;

  // item functions
  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_READ  = 1'b1;

  // configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS = 1'b1;

  // mapping result passed from the index map to the top level
  typedef struct packed {
    logic              ok;
    logic [ADDR_W-1:0] addr;
  } map_res_t;

  // clamp a register value to the capacity of its axis
  function automatic logic [EXT_W-1:0] eff_dim(input logic [DIM_W-1:0] reg_val,
                                               input logic [EXT_W-1:0] cap);
    logic [EXT_W-1:0] v;
    v = EXT_W'(reg_val);
    return (v > cap) ? cap : v;
  endfunction

endpackage

// ===== src/mtmr_addr_map.sv =====
// maps write and tiled read coordinates onto a source store address
module mtmr_addr_map (
  input  logic                        func,
  input  logic [mtmr_pkg::IDX_W-1:0]  row_index,
  input  logic [mtmr_pkg::IDX_W-1:0]  col_index,
  input  logic [mtmr_pkg::DIM_W-1:0]  rows_in_use,
  input  logic [mtmr_pkg::DIM_W-1:0]  cols_in_use,
  output mtmr_pkg::map_res_t          map_res
);

  logic [mtmr_pkg::EXT_W-1:0] nr;
  logic [mtmr_pkg::EXT_W-1:0] nc;
  logic [mtmr_pkg::EXT_W-1:0] tr;
  logic [mtmr_pkg::EXT_W-1:0] tc;
  logic [mtmr_pkg::EXT_W-1:0] nr2;
  logic [mtmr_pkg::EXT_W-1:0] nr3;
  logic [mtmr_pkg::EXT_W-1:0] nc2;
  logic [mtmr_pkg::EXT_W-1:0] nc3;
  logic [mtmr_pkg::EXT_W-1:0] sr;
  logic [mtmr_pkg::EXT_W-1:0] sc;
  logic                       row_ok;
  logic                       col_ok;
  logic [mtmr_pkg::AEXT_W-1:0] addr_ext;

  // effective dimensions and tile boundaries
  assign nr  = mtmr_pkg::eff_dim(rows_in_use, mtmr_pkg::EXT_W'(mtmr_pkg::MAX_ROWS));
  assign nc  = mtmr_pkg::eff_dim(cols_in_use, mtmr_pkg::EXT_W'(mtmr_pkg::MAX_COLS));
  assign tr  = mtmr_pkg::EXT_W'(row_index);
  assign tc  = mtmr_pkg::EXT_W'(col_index);
  assign nr2 = nr << 1;
  assign nr3 = nr2 + nr;
  assign nc2 = nc << 1;
  assign nc3 = nc2 + nc;

  // row axis: direct on write, mirrored tile select on read
  always_comb begin
    if (func == mtmr_pkg::FUNC_WRITE) begin
      row_ok = (tr < nr);
      sr     = tr;
    end else begin
      row_ok = (nr != '0) && (tr < nr3);
      if (tr < nr) begin
        sr = nr - 1'b1 - tr;
      end else if (tr < nr2) begin
        sr = tr - nr;
      end else begin
        sr = nr3 - 1'b1 - tr;
      end
    end
  end

  // column axis
  always_comb begin
    if (func == mtmr_pkg::FUNC_WRITE) begin
      col_ok = (tc < nc);
      sc     = tc;
    end else begin
      col_ok = (nc != '0) && (tc < nc3);
      if (tc < nc) begin
        sc = nc - 1'b1 - tc;
      end else if (tc < nc2) begin
        sc = tc - nc;
      end else begin
        sc = nc3 - 1'b1 - tc;
      end
    end
  end

  // flattened address row * MAX_COLS + col
  assign addr_ext = mtmr_pkg::AEXT_W'(sr[mtmr_pkg::ROW_W-1:0])
                    * mtmr_pkg::AEXT_W'(mtmr_pkg::MAX_COLS)
                    + mtmr_pkg::AEXT_W'(sc[mtmr_pkg::COL_W-1:0]);

  assign map_res.ok   = row_ok && col_ok;
  assign map_res.addr = addr_ext[mtmr_pkg::ADDR_W-1:0];

endmodule

// ===== src/mtmr_store.sv =====
// element store: single port synchronous memory with registered read data
module mtmr_store (
  input  logic                         clk,
  input  logic                         we,
  input  logic                         re,
  input  logic [mtmr_pkg::ADDR_W-1:0]  addr,
  input  logic [mtmr_pkg::DATA_W-1:0]  wdata,
  output logic [mtmr_pkg::DATA_W-1:0]  rdata
);

  logic [mtmr_pkg::DATA_W-1:0] mem [mtmr_pkg::DEPTH];
  logic [mtmr_pkg::DATA_W-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== src/mirror_tiled_matrix_reader_core.sv =====
// top level: config registers, store access stage and output register
// a read result is registered by the store read port, then loaded into the output register
// throughput: one item per cycle while the output is not stalled; writes give no result
// the single store port serves either the write or the read of each item
// reset (rst_n low, synchronous) clears handshake state and sets both dimensions to 1
// store contents are undefined after reset until written; no clearing pass
module mirror_tiled_matrix_reader_core (
  input  logic                            clk,
  input  logic                            rst_n,
  // input channel
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_func,
  input  logic [mtmr_pkg::IDX_W-1:0]      in_row_index,
  input  logic [mtmr_pkg::IDX_W-1:0]      in_col_index,
  input  logic [mtmr_pkg::DATA_W-1:0]     in_write_value,
  // result channel
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [mtmr_pkg::DATA_W-1:0]     out_read_value,
  output logic                            out_out_of_range,
  // configuration channel
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [mtmr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mtmr_pkg::DIM_W-1:0]      cfg_wdata
);

  logic [mtmr_pkg::DIM_W-1:0]  rows_r;
  logic [mtmr_pkg::DIM_W-1:0]  cols_r;
  mtmr_pkg::map_res_t          map_res;
  logic                        in_xfer;
  logic                        mem_we;
  logic                        mem_re;
  logic [mtmr_pkg::DATA_W-1:0] mem_rdata;
  logic                        s1_valid_r;
  logic                        s1_valid_nxt;
  logic                        s1_oor_r;
  logic                        s1_move;
  logic                        out_valid_r;
  logic                        out_valid_nxt;
  logic [mtmr_pkg::DATA_W-1:0] out_value_r;
  logic                        out_oor_r;

  // configuration registers, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= mtmr_pkg::DIM_W'(1);
      cols_r <= mtmr_pkg::DIM_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        mtmr_pkg::CFG_ROWS: rows_r <= cfg_wdata;
        mtmr_pkg::CFG_COLS: cols_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // coordinate mapping
  mtmr_addr_map u_map (
    .func        (in_func),
    .row_index   (in_row_index),
    .col_index   (in_col_index),
    .rows_in_use (rows_r),
    .cols_in_use (cols_r),
    .map_res     (map_res)
  );

  // stage 1 moves on when the output register is free or being drained
  assign s1_move  = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !s1_move;
  assign in_xfer  = in_valid && !in_stall;

  // store access
  assign mem_we = in_xfer && (in_func == mtmr_pkg::FUNC_WRITE) && map_res.ok;
  assign mem_re = in_xfer && (in_func == mtmr_pkg::FUNC_READ) && map_res.ok;

  mtmr_store u_store (
    .clk   (clk),
    .we    (mem_we),
    .re    (mem_re),
    .addr  (map_res.addr),
    .wdata (in_write_value),
    .rdata (mem_rdata)
  );

  // read item waiting on store data
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (s1_move) begin
      s1_valid_nxt = 1'b0;
    end
    if (in_xfer && (in_func == mtmr_pkg::FUNC_READ)) begin
      s1_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && (in_func == mtmr_pkg::FUNC_READ)) begin
      s1_oor_r <= !map_res.ok;
    end
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (s1_move) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_value_r <= s1_oor_r ? '0 : mem_rdata;
      out_oor_r   <= s1_oor_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_read_value   = out_value_r;
  assign out_out_of_range = out_oor_r;

endmodule

// ===== sim/mirror_read_checker.sv =====
// checker for the mirror tiled matrix reader: watches all channels, predicts and compares reads
`timescale 1ns / 100ps

module mirror_read_checker (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  logic                                in_stall,
  input  logic                                in_func,
  input  logic [mtmr_pkg::IDX_W-1:0]          in_row_index,
  input  logic [mtmr_pkg::IDX_W-1:0]          in_col_index,
  input  logic [mtmr_pkg::DATA_W-1:0]         in_write_value,
  input  logic                                out_valid,
  input  logic                                out_stall,
  input  logic [mtmr_pkg::DATA_W-1:0]         out_read_value,
  input  logic                                out_out_of_range,
  input  logic                                cfg_valid,
  input  logic                                cfg_ready,
  input  logic [mtmr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mtmr_pkg::DIM_W-1:0]          cfg_wdata,
  output int                                  pending_reads,
  output int                                  fail_count
);

  localparam int MAX_PRINTS = 25;

  // one predicted read result
  typedef struct packed {
    logic [mtmr_pkg::DATA_W-1:0] value;
    logic                        oor;
  } tile_read_t;

  tile_read_t                  expected_reads[$];
  tile_read_t                  exp_r;
  logic [mtmr_pkg::DATA_W-1:0] shadow_store [mtmr_pkg::MAX_ROWS*mtmr_pkg::MAX_COLS];
  logic [mtmr_pkg::DIM_W-1:0]  rows_cfg;
  logic [mtmr_pkg::DIM_W-1:0]  cols_cfg;
  int unsigned                 nr;
  int unsigned                 nc;
  int unsigned                 sr;
  int unsigned                 sc;
  int                          mismatches = 0;
  int                          reads_seen = 0;

  // register value saturated to the capacity of its axis
  function automatic int unsigned clamp_dim(input logic [mtmr_pkg::DIM_W-1:0] v,
                                            input int unsigned cap);
    return (v > cap) ? cap : int'(v);
  endfunction

  // fold a tiled coordinate back onto the source axis; 0 when outside the tiling
  function automatic bit fold_axis(input int unsigned t, input int unsigned n,
                                   output int unsigned src);
    src = 0;
    if (n == 0 || t >= 3 * n) return 1'b0;
    if (t < n) src = n - 1 - t;
    else if (t < 2 * n) src = t - n;
    else src = 3 * n - 1 - t;
    return 1'b1;
  endfunction

  task automatic flag_mismatch(input string msg);
    if (mismatches < MAX_PRINTS) $display("[%0t] MISMATCH: %s", $time, msg);
    mismatches++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      rows_cfg = mtmr_pkg::DIM_W'(1);
      cols_cfg = mtmr_pkg::DIM_W'(1);
      expected_reads.delete();
    end else begin
      // register writes are to land only while idle; this checker does not enforce it
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == mtmr_pkg::CFG_ROWS) rows_cfg = cfg_wdata;
        else if (cfg_index == mtmr_pkg::CFG_COLS) cols_cfg = cfg_wdata;
      end

      // result transfer against the oldest prediction
      if (out_valid && !out_stall) begin
        if (expected_reads.size() == 0) begin
          flag_mismatch($sformatf("unexpected result value=%h oor=%b",
                                  out_read_value, out_out_of_range));
        end else begin
          exp_r = expected_reads.pop_front();
          if (out_read_value !== exp_r.value)
            flag_mismatch($sformatf("read %0d: value %h, expected %h",
                                    reads_seen, out_read_value, exp_r.value));
          if (out_out_of_range !== exp_r.oor)
            flag_mismatch($sformatf("read %0d: out_of_range %b, expected %b",
                                    reads_seen, out_out_of_range, exp_r.oor));
        end
        reads_seen++;
      end

      // input transfer: update the shadow store or predict a read
      if (in_valid && !in_stall) begin
        nr = clamp_dim(rows_cfg, mtmr_pkg::MAX_ROWS);
        nc = clamp_dim(cols_cfg, mtmr_pkg::MAX_COLS);
        if (in_func == mtmr_pkg::FUNC_WRITE) begin
          if (in_row_index < nr && in_col_index < nc)
            shadow_store[in_row_index * mtmr_pkg::MAX_COLS + in_col_index] = in_write_value;
        end else begin
          if (fold_axis(in_row_index, nr, sr) && fold_axis(in_col_index, nc, sc)) begin
            exp_r.value = shadow_store[sr * mtmr_pkg::MAX_COLS + sc];
            exp_r.oor   = 1'b0;
          end else begin
            exp_r.value = '0;
            exp_r.oor   = 1'b1;
          end
          expected_reads = {expected_reads, exp_r};
        end
      end
    end
    pending_reads <= expected_reads.size();
    fail_count    <= mismatches;
  end

endmodule

// ===== sim/testbench.sv =====
// top of the testbench: clock, reset, stimulus, output stall pattern and verdict
`timescale 1ns / 100ps

module testbench;

  localparam int PHASE_ITEMS    = 140;
  localparam int DRAIN_CYCLES   = 4;
  localparam int WATCHDOG_LIMIT = 3000;

  typedef enum logic [1:0] {STALL_NONE, STALL_COIN, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

  logic                           clk = 1'b0;
  logic                           rst_n;
  logic                           in_valid;
  logic                           in_stall;
  logic                           in_func;
  logic [mtmr_pkg::IDX_W-1:0]     in_row_index;
  logic [mtmr_pkg::IDX_W-1:0]     in_col_index;
  logic [mtmr_pkg::DATA_W-1:0]    in_write_value;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  logic [mtmr_pkg::DATA_W-1:0]    out_read_value;
  logic                           out_out_of_range;
  logic                           cfg_valid;
  logic                           cfg_ready;
  logic [mtmr_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [mtmr_pkg::DIM_W-1:0]     cfg_wdata;
  int                             pending_reads;
  int                             fail_count;

  // stimulus bookkeeping
  bit                         written [mtmr_pkg::MAX_ROWS][mtmr_pkg::MAX_COLS];
  logic [mtmr_pkg::DIM_W-1:0] rows_reg = mtmr_pkg::DIM_W'(1);
  logic [mtmr_pkg::DIM_W-1:0] cols_reg = mtmr_pkg::DIM_W'(1);
  int unsigned                burst_left = 0;
  int                         writes_sent = 0;
  int                         reads_sent = 0;
  int                         outside_reads = 0;
  int                         shapes = 0;

  // output stall pattern state
  stall_mode_t stall_mode = STALL_NONE;
  int unsigned stall_left = 0;
  logic [31:0] cycle_no = 0;
  int          idle_cycles = 0;

  mirror_tiled_matrix_reader_core dut (.*);

  mirror_read_checker read_check (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver stalls in modes that change at random
  always @(posedge clk) begin
    cycle_no <= cycle_no + 1;
    if (stall_left == 0) begin
      stall_mode <= stall_mode_t'($urandom_range(0, 3));
      stall_left <= $urandom_range(16, 160);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_COIN:  out_stall <= ($urandom_range(0, 1) == 1);
      STALL_HEAVY: out_stall <= ($urandom_range(0, 9) < 8);
      default:     out_stall <= (cycle_no[2:0] > 3'd4);
    endcase
  end

  // watchdog on cycles with no transfer on any channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("ERROR: no transfer for %0d cycles, %0d reads outstanding",
               idle_cycles, pending_reads);
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic int unsigned dim_cap(input logic [mtmr_pkg::DIM_W-1:0] v,
                                          input int unsigned cap);
    return (v > cap) ? cap : int'(v);
  endfunction

  // pick one of the three tiles and map a source coordinate into it
  function automatic int unsigned mirror_coord(input int unsigned s, input int unsigned n);
    int unsigned tile;
    tile = $urandom_range(0, 2);
    if (tile == 0) return n - 1 - s;
    if (tile == 1) return n + s;
    return 3 * n - 1 - s;
  endfunction

  // one input transfer, sent in bursts with random gaps
  task automatic offer_item(input logic func, input logic [mtmr_pkg::IDX_W-1:0] r,
                            input logic [mtmr_pkg::IDX_W-1:0] c,
                            input logic [mtmr_pkg::DATA_W-1:0] v);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_valid       <= 1'b1;
    in_func        <= func;
    in_row_index   <= r;
    in_col_index   <= c;
    in_write_value <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    burst_left--;
  endtask

  task automatic write_elem(input int unsigned r, input int unsigned c,
                            input logic [mtmr_pkg::DATA_W-1:0] v);
    if (r < dim_cap(rows_reg, mtmr_pkg::MAX_ROWS) && c < dim_cap(cols_reg, mtmr_pkg::MAX_COLS))
      written[r][c] = 1'b1;
    writes_sent++;
    offer_item(mtmr_pkg::FUNC_WRITE, mtmr_pkg::IDX_W'(r), mtmr_pkg::IDX_W'(c), v);
  endtask

  task automatic read_tiled(input int unsigned r, input int unsigned c);
    reads_sent++;
    offer_item(mtmr_pkg::FUNC_READ, mtmr_pkg::IDX_W'(r), mtmr_pkg::IDX_W'(c),
               {$urandom, $urandom});
  endtask

  // drop valid and wait until every read result is back and writes have drained
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_reads != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // write both size registers while the block is idle
  task automatic set_shape(input logic [mtmr_pkg::DIM_W-1:0] r,
                           input logic [mtmr_pkg::DIM_W-1:0] c);
    settle();
    cfg_valid <= 1'b1;
    cfg_index <= mtmr_pkg::CFG_ROWS;
    cfg_wdata <= r;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_index <= mtmr_pkg::CFG_COLS;
    cfg_wdata <= c;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    rows_reg = r;
    cols_reg = c;
    shapes++;
  endtask

  // mostly writes and in-range reads of written elements, some reads past the tiling and writes at random coordinates
  task automatic random_item();
    int unsigned nr;
    int unsigned nc;
    int unsigned kind;
    int unsigned pick;
    int unsigned r;
    int unsigned c;
    int unsigned sr;
    int unsigned sc;
    nr   = dim_cap(rows_reg, mtmr_pkg::MAX_ROWS);
    nc   = dim_cap(cols_reg, mtmr_pkg::MAX_COLS);
    kind = $urandom_range(0, 99);
    if (nr == 0 || nc == 0) begin
      // empty matrix: every read is outside, every write ignored
      if (kind < 70) begin
        outside_reads++;
        read_tiled($urandom_range(0, 127), $urandom_range(0, 127));
      end else begin
        write_elem($urandom_range(0, 127), $urandom_range(0, 127), {$urandom, $urandom});
      end
    end else if (kind < 14) begin
      pick = $urandom_range(0, 2);
      r = (pick != 1) ? $urandom_range(3 * nr, 127) : $urandom_range(0, 3 * nr - 1);
      c = (pick != 0) ? $urandom_range(3 * nc, 127) : $urandom_range(0, 3 * nc - 1);
      outside_reads++;
      read_tiled(r, c);
    end else if (kind < 22) begin
      write_elem($urandom_range(0, 127), $urandom_range(0, 127), {$urandom, $urandom});
    end else begin
      sr = $urandom_range(0, nr - 1);
      sc = $urandom_range(0, nc - 1);
      if (kind < 48 || !written[sr][sc])
        write_elem(sr, sc, {$urandom, $urandom});
      else
        read_tiled(mirror_coord(sr, nr), mirror_coord(sc, nc));
    end
  endtask

  initial begin
    logic [mtmr_pkg::DIM_W-1:0] shape_rows [12];
    logic [mtmr_pkg::DIM_W-1:0] shape_cols [12];
    shape_rows = '{6'd1, 6'd32, 6'd0, 6'd9, 6'd63, 6'd1, 6'd32, 6'd5, 6'd17, 6'd40, 6'd2, 6'd3};
    shape_cols = '{6'd1, 6'd32, 6'd7, 6'd0, 6'd45, 6'd32, 6'd1, 6'd13, 6'd3, 6'd63, 6'd2, 6'd3};
    shape_rows[10] = mtmr_pkg::DIM_W'($urandom_range(1, 32));
    shape_cols[11] = mtmr_pkg::DIM_W'($urandom_range(1, 32));

    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_func        = mtmr_pkg::FUNC_WRITE;
    in_row_index   = '0;
    in_col_index   = '0;
    in_write_value = '0;
    cfg_valid      = 1'b0;
    cfg_index      = mtmr_pkg::CFG_ROWS;
    cfg_wdata      = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset shape 1x1: all nine tiles fold onto the one element
    write_elem(0, 0, '1);
    read_tiled(0, 0);
    read_tiled(1, 1);
    read_tiled(2, 2);
    read_tiled(2, 0);
    read_tiled(0, 2);
    // writes outside the source matrix are dropped
    write_elem(0, 1, {$urandom, $urandom});
    write_elem(1, 0, {$urandom, $urandom});
    write_elem(127, 127, {$urandom, $urandom});
    // reads just past and far past the tiling
    read_tiled(3, 0);
    read_tiled(0, 3);
    read_tiled(127, 127);
    write_elem(0, 0, '0);
    read_tiled(1, 1);

    // full size: corners, tile boundaries and the first coordinate past the tiling
    set_shape(6'd32, 6'd32);
    write_elem(31, 31, {32'haaaa_aaaa, 32'haaaa_aaaa});
    write_elem(0, 0, {32'h5555_5555, 32'h5555_5555});
    write_elem(0, 31, {$urandom, $urandom});
    read_tiled(0, 0);
    read_tiled(95, 95);
    read_tiled(32, 32);
    read_tiled(31, 64);
    read_tiled(96, 0);
    read_tiled(0, 96);

    // random phases over several shapes, including empty and saturated ones
    for (int p = 0; p < 12; p++) begin
      set_shape(shape_rows[p], shape_cols[p]);
      for (int i = 0; i < PHASE_ITEMS; i++) random_item();
    end

    settle();
    $display("covered %0d items: %0d writes, %0d reads (%0d aimed outside the tiling)",
             writes_sent + reads_sent, writes_sent, reads_sent, outside_reads);
    $display("over %0d matrix shapes, with empty, saturated and full-size ones", shapes + 1);
    if (fail_count == 0 && pending_reads == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
